### hdl/wag_pkg.sv
// Package for the window-apply block: widths, window constants, item types,
// the back-end state codes and the quarter-wave cosine table builder.
// No dependencies.
`default_nettype none
package wag_pkg;

    // Fixed sizes of the datapath
    localparam int PHASE_BITS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LENGTH  = 4096;
    localparam int COS_LOG2    = 10;
    localparam int COS_DEPTH   = 1 << COS_LOG2;
    localparam int COS_AW      = COS_LOG2 + 1;
    localparam int IDX_SHIFT   = PHASE_BITS - 2 - COS_LOG2;
    localparam int LEN_W       = 13;
    localparam int IDX_W       = 12;
    localparam int SUM_W       = 28;
    localparam int SQ_W        = 43;
    localparam int COEF_W      = 16;

    // Serial divider sizes
    localparam int DIV_W  = 71;
    localparam int DIVR_W = 56;
    localparam int QUO_W  = 18;
    localparam int CNT_W  = 7;

    // Q15 window constants
    localparam int ONE_Q15 = 32768;
    localparam int C_HALF  = 16384;
    localparam int C_054   = 17695;
    localparam int C_046   = 15073;
    localparam int C_042   = 13763;
    localparam int C_008   = 2621;

    // Register map
    localparam logic [1:0] REG_KIND    = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_COMPLEX = 2'd2;

    typedef enum logic [1:0] {
        KIND_RECT,
        KIND_HANN,
        KIND_HAMMING,
        KIND_BLACKMAN
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVSTEP,
        ST_ROM,
        ST_MUL,
        ST_COEF,
        ST_APPLY,
        ST_GMUL,
        ST_GDIV_CG,
        ST_GDIV_NB,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_real;
        logic signed [SAMPLE_BITS-1:0] sample_imag;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] windowed_real;
        logic signed [SAMPLE_BITS-1:0] windowed_imag;
        logic [COEF_W-1:0]             window_coefficient;
        logic                          last_in_window;
        logic [15:0]                   mean_gain;
        logic [15:0]                   noise_bandwidth_bins;
        logic                          gain_error;
    } out_item_t;

    // Settings handed from the register file to the back end
    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  len;
        logic              is_complex;
        logic              restart;
    } cfg_t;

    typedef logic [15:0] cos_rom_t [0:COS_DEPTH];

    // Quarter-wave cosine in Q15 from a Q30 Taylor series through x^18
    function automatic cos_rom_t build_cos_table();
        cos_rom_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      acc;
        longint      e;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x   = (64'd1686629713 * 64'(k) + 64'(COS_DEPTH / 2)) / 64'(COS_DEPTH);
            x2  = (x * x) >> 30;
            t   = 64'd1 << 30;
            acc = $signed(t);
            for (int n = 1; n <= 9; n++) begin
                t = ((t * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n[0]) acc = acc - $signed(t);
                else acc = acc + $signed(t);
            end
            if (acc < 0) acc = 0;
            e = (acc + 16384) >>> 15;
            if (e > ONE_Q15) e = ONE_Q15;
            tab[k] = 16'(e);
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

### hdl/wag_front.sv
// Front end: two-entry input queue that takes items from the input channel
// and holds them for the back end. Depends on wag_pkg.
`default_nettype none
module wag_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire wag_pkg::in_item_t s_payload,
    output logic                   q_valid,
    output wag_pkg::in_item_t      q_item,
    input  wire logic              q_pop
);
    import wag_pkg::*;

    in_item_t   slot_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !q_pop) count_reg <= count_reg + 2'd1;
            else if (!push && q_pop) count_reg <= count_reg - 2'd1;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= s_payload;
    end

endmodule
`default_nettype wire

### hdl/wag_cos_rom.sv
// Quarter-wave cosine ROM with two registered read ports.
// Depends on wag_pkg for the table builder.
`default_nettype none
module wag_cos_rom (
    input  wire logic                      aclk,
    input  wire logic [wag_pkg::COS_AW-1:0] addr_a,
    input  wire logic [wag_pkg::COS_AW-1:0] addr_b,
    output logic [15:0]                    rd_a,
    output logic [15:0]                    rd_b
);
    import wag_pkg::*;

    localparam cos_rom_t COS_TABLE = build_cos_table();

    always_ff @(posedge aclk) begin
        rd_a <= COS_TABLE[addr_a];
        rd_b <= COS_TABLE[addr_b];
    end

endmodule
`default_nettype wire

### hdl/wag_div.sv
// Shared restoring divider, one quotient bit a cycle. The dividend comes
// left-aligned; nbits sets the number of steps. Depends on wag_pkg.
`default_nettype none
module wag_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [wag_pkg::DIV_W-1:0]   dividend,
    input  wire logic [wag_pkg::DIVR_W-1:0]  divisor,
    input  wire logic [wag_pkg::CNT_W-1:0]   nbits,
    output logic                             done,
    output logic [wag_pkg::QUO_W-1:0]        quo,
    output logic                             ovf,
    output logic [wag_pkg::DIVR_W-1:0]       rem
);
    import wag_pkg::*;

    logic [DIV_W-1:0]  dvd_reg;
    logic [DIVR_W-1:0] dsr_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIVR_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;
    assign ovf   = ovf_reg;
    assign rem   = rem_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift, trial subtract
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= fits ? DIVR_W'(trial - {1'b0, dsr_reg}) : trial[DIVR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
        end
    end

endmodule
`default_nettype wire

### hdl/wag_back.sv
// Back end: frame tracking, coefficient generation, sample scaling and the
// gains at frame end. Depends on wag_pkg, wag_cos_rom and wag_div.
`default_nettype none
module wag_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire wag_pkg::cfg_t      cfg,
    input  wire logic               q_valid,
    input  wire wag_pkg::in_item_t  q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output wag_pkg::out_item_t      m_payload
);
    import wag_pkg::*;

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0]      sample_index_reg;
    logic [PHASE_BITS-1:0] phase_q_reg, step_q_reg;
    logic [IDX_W-1:0]      phase_r_reg, step_r_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [COEF_W-1:0]     coef_reg;
    logic signed [33:0]    m1_reg, m2_reg;
    logic                  n1_reg, n2_reg;
    logic [34:0]           pp_lo_reg;
    logic [33:0]           pp_hi_reg;
    logic [DIVR_W-1:0]     den2_reg, num_reg;
    out_item_t             out_reg;

    logic [IDX_W-1:0]      den;
    logic                  need_step, is_last;
    logic [COS_AW-1:0]     addr_a, addr_b;
    logic                  neg_a, neg_b;
    logic [15:0]           rd_a, rd_b;
    logic                  div_start, div_done, div_ovf;
    logic [DIV_W-1:0]      div_dividend;
    logic [DIVR_W-1:0]     div_divisor, div_rem;
    logic [CNT_W-1:0]      div_nbits;
    logic [QUO_W-1:0]      div_quo;
    logic [PHASE_BITS-1:0] phase2;
    logic [12:0]           rem_sum;

    assign den       = IDX_W'(cfg.len - LEN_W'(1));
    assign need_step = (sample_index_reg == '0) || ({1'b0, sample_index_reg} >= cfg.len);
    assign is_last   = (sample_index_reg == den);
    assign phase2    = {phase_q_reg[PHASE_BITS-2:0], 1'b0};
    assign rem_sum   = {1'b0, phase_r_reg} + {1'b0, step_r_reg};
    assign m_valid   = (state_reg == ST_OUT);
    assign m_payload = out_reg;

    // phase to table address, with quadrant folding
    function automatic logic [COS_AW:0] fold(input logic [PHASE_BITS-1:0] p);
        logic [1:0]            quad;
        logic [PHASE_BITS-2:0] pos;
        logic [COS_AW-1:0]     idx;
        quad = p[PHASE_BITS-1:PHASE_BITS-2];
        pos  = {1'b0, p[PHASE_BITS-3:0]};
        idx  = COS_AW'((pos + (PHASE_BITS-1)'(1 << (IDX_SHIFT - 1))) >> IDX_SHIFT);
        if (quad[0]) idx = COS_AW'(COS_DEPTH) - idx;
        return {quad[0] ^ quad[1], idx};
    endfunction

    assign {neg_a, addr_a} = fold(phase_q_reg);
    assign {neg_b, addr_b} = fold(phase2);

    wag_cos_rom u_rom (
        .aclk   (aclk),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

    wag_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .done     (div_done),
        .quo      (div_quo),
        .ovf      (div_ovf),
        .rem      (div_rem)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // next state, divider commands, queue pop
    always_comb begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_nbits    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (need_step) begin
                        div_start    = 1'b1;
                        div_dividend = {1'b1, {(DIV_W-1){1'b0}}};
                        div_divisor  = DIVR_W'(den);
                        div_nbits    = CNT_W'(PHASE_BITS + 1);
                        state_next   = ST_DIVSTEP;
                    end else begin
                        state_next = ST_ROM;
                    end
                end
            end
            ST_DIVSTEP: if (div_done) state_next = ST_ROM;
            ST_ROM:     state_next = ST_MUL;
            ST_MUL:     state_next = ST_COEF;
            ST_COEF:    state_next = ST_APPLY;
            ST_APPLY: begin
                q_pop      = 1'b1;
                state_next = is_last ? ST_GMUL : ST_OUT;
            end
            ST_GMUL: begin
                if (sum_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {SUM_W'(sum_reg + SUM_W'(cfg.len >> 1)),
                                    {(DIV_W-SUM_W){1'b0}}};
                    div_divisor  = DIVR_W'(cfg.len);
                    div_nbits    = CNT_W'(SUM_W);
                    state_next   = ST_GDIV_CG;
                end
            end
            ST_GDIV_CG: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = {num_reg, 15'b0};
                    div_divisor  = den2_reg;
                    div_nbits    = CNT_W'(DIV_W);
                    state_next   = ST_GDIV_NB;
                end
            end
            ST_GDIV_NB: if (div_done) state_next = ST_OUT;
            ST_OUT:     if (m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // frame state: index, phase, step, sums
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.restart) begin
            sample_index_reg <= '0;
            phase_q_reg      <= '0;
            phase_r_reg      <= '0;
            step_q_reg       <= '0;
            step_r_reg       <= '0;
            sum_reg          <= '0;
            sq_reg           <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && need_step) begin
                        sample_index_reg <= '0;
                        phase_q_reg      <= '0;
                        phase_r_reg      <= '0;
                        sum_reg          <= '0;
                        sq_reg           <= '0;
                    end
                end
                ST_DIVSTEP: begin
                    if (div_done) begin
                        step_q_reg <= div_quo[PHASE_BITS-1:0];
                        step_r_reg <= div_rem[IDX_W-1:0];
                    end
                end
                ST_APPLY: begin
                    sum_reg <= sum_reg + SUM_W'(coef_reg);
                    sq_reg  <= sq_reg + SQ_W'(coef_reg * coef_reg);
                    if (is_last) begin
                        sample_index_reg <= '0;
                    end else begin
                        sample_index_reg <= sample_index_reg + 1'b1;
                        if (rem_sum >= {1'b0, den}) begin
                            phase_r_reg <= IDX_W'(rem_sum - {1'b0, den});
                            phase_q_reg <= phase_q_reg + step_q_reg + 1'b1;
                        end else begin
                            phase_r_reg <= rem_sum[IDX_W-1:0];
                            phase_q_reg <= phase_q_reg + step_q_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // coefficient pipeline and result fields
    always_ff @(posedge aclk) begin
        logic signed [17:0] c1, c2;
        logic signed [35:0] acc;
        logic signed [35:0] rnd;
        logic signed [32:0] pr, pi;
        logic [16:0]        a1;
        logic [17:0]        a0;
        logic [QUO_W-1:0]   nb;
        n1_reg <= neg_a;
        n2_reg <= neg_b;
        c1 = n1_reg ? -$signed({2'b0, rd_a}) : $signed({2'b0, rd_a});
        c2 = n2_reg ? -$signed({2'b0, rd_b}) : $signed({2'b0, rd_b});
        a1 = (cfg.kind == KIND_HAMMING) ? 17'(C_046) : 17'(C_HALF);
        case (cfg.kind)
            KIND_HAMMING:  a0 = 18'(C_054);
            KIND_BLACKMAN: a0 = 18'(C_042);
            default:       a0 = 18'(C_HALF);
        endcase
        case (state_reg)
            ST_MUL: begin
                m1_reg <= 34'($signed({1'b0, a1}) * c1);
                m2_reg <= 34'($signed(18'(C_008)) * c2);
            end
            ST_COEF: begin
                acc = $signed({3'b0, a0, 15'b0}) - 36'(m1_reg);
                if (cfg.kind == KIND_BLACKMAN) acc = acc + 36'(m2_reg);
                if (acc < 0) acc = '0;
                rnd = (acc + 36'sd16384) >>> 15;
                if (cfg.kind == KIND_RECT || rnd > 36'sd32768) coef_reg <= 16'(ONE_Q15);
                else coef_reg <= rnd[COEF_W-1:0];
            end
            ST_APPLY: begin
                pr = $signed(q_item.sample_real) * $signed({1'b0, coef_reg}) + 33'sd16384;
                pi = $signed(q_item.sample_imag) * $signed({1'b0, coef_reg}) + 33'sd16384;
                out_reg.windowed_real        <= pr[30:15];
                out_reg.windowed_imag        <= cfg.is_complex ? pi[30:15] : '0;
                out_reg.window_coefficient   <= coef_reg;
                out_reg.last_in_window       <= is_last;
                out_reg.mean_gain            <= '0;
                out_reg.noise_bandwidth_bins <= '0;
                out_reg.gain_error           <= 1'b0;
            end
            ST_GMUL: begin
                pp_lo_reg <= sq_reg[21:0] * cfg.len;
                pp_hi_reg <= sq_reg[SQ_W-1:22] * cfg.len;
                den2_reg  <= DIVR_W'(sum_reg * sum_reg);
                if (sum_reg == '0) out_reg.gain_error <= 1'b1;
            end
            ST_GDIV_CG: begin
                num_reg <= DIVR_W'({pp_hi_reg, 22'b0} + {21'b0, pp_lo_reg});
                if (div_done) begin
                    if (div_quo > QUO_W'(ONE_Q15)) out_reg.mean_gain <= 16'(ONE_Q15);
                    else out_reg.mean_gain <= div_quo[15:0];
                end
            end
            ST_GDIV_NB: begin
                nb = (div_quo + 1'b1) >> 1;
                if (div_done) begin
                    if (div_ovf || div_quo[QUO_W-1] || nb[QUO_W-1:16] != '0)
                        out_reg.noise_bandwidth_bins <= 16'hFFFF;
                    else out_reg.noise_bandwidth_bins <= nb[15:0];
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### hdl/window_apply_with_gains_top.sv
// Top level of the window-apply block: APB register file, input queue and
// back end. Depends on wag_pkg, wag_front and wag_back.
//
// Usage:
//   Samples enter on s_valid/s_ready/s_payload, windowed results leave on
//   m_valid/m_ready/m_payload, one result per sample, in order.
//   Registers (APB, 32-bit, byte address 4*index): window kind, window
//   length, complex mode. Writing kind or length restarts the frame.
//   A two-entry queue parts the input from the back end, so up to two
//   samples are taken while a result waits.
//   Each sample passes through the back-end sequencer in order (queue pick-up,
//   table read, coefficient multiply, coefficient round, sample scale,
//   output hand-over).
//   The first sample of a frame first waits for the step division in
//   the shared serial divider; the last adds the gain products and the
//   two divisions (28 and 71 steps), or only the gain-product step when
//   the coefficient sum is zero.
//   At reset the registers take kind hann, length 1024, real mode; the
//   queue empties and a new frame begins. No clearing pass is needed.
//   While m_ready is low the result is held and the sequencer waits; the
//   queue keeps accepting until full.
`default_nettype none
module window_apply_with_gains_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wag_pkg::in_item_t   s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wag_pkg::out_item_t       m_payload,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import wag_pkg::*;

    kind_t            kind_reg;
    logic [LEN_W-1:0] length_reg;
    logic             complex_reg;
    logic             wr_en, restart;
    logic [1:0]       reg_idx;
    logic [LEN_W-1:0] len_eff;
    cfg_t             cfg;
    logic             q_valid, q_pop;
    in_item_t         q_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign restart = wr_en && (reg_idx == REG_KIND || reg_idx == REG_LENGTH);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= KIND_HANN;
            length_reg  <= LEN_W'(1024);
            complex_reg <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KIND:    kind_reg    <= kind_t'(pwdata[1:0]);
                REG_LENGTH:  length_reg  <= pwdata[LEN_W-1:0];
                REG_COMPLEX: complex_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_KIND:    prdata = {30'b0, kind_reg};
            REG_LENGTH:  prdata = {{(32-LEN_W){1'b0}}, length_reg};
            REG_COMPLEX: prdata = {31'b0, complex_reg};
            default:     prdata = '0;
        endcase
    end

    // effective length, held within 2 .. MAX_LENGTH
    always_comb begin
        if (length_reg < LEN_W'(2)) len_eff = LEN_W'(2);
        else if (length_reg > LEN_W'(MAX_LENGTH)) len_eff = LEN_W'(MAX_LENGTH);
        else len_eff = length_reg;
    end

    assign cfg = '{kind: kind_reg, len: len_eff, is_complex: complex_reg, restart: restart};

    wag_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    wag_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    // gains and error only ever appear on the last item of a frame
    a_gains_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.last_in_window |->
            m_payload.mean_gain == 16'd0 && m_payload.noise_bandwidth_bins == 16'd0
            && !m_payload.gain_error)
        else $error("gain fields set on an item that is not last");

    // a zero sum reports no gains
    a_error_zero_gains: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.gain_error |->
            m_payload.mean_gain == 16'd0 && m_payload.noise_bandwidth_bins == 16'd0)
        else $error("gain error with non-zero gains");

    // real mode forces the imaginary output to zero
    a_real_imag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !complex_reg |-> m_payload.windowed_imag == 16'sd0)
        else $error("imaginary output set in real mode");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for window_apply_with_gains_top: drives samples and APB writes,
// predicts every windowed item with its own window model, checks in order.
// Depends on wag_pkg and the RTL top level.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wag_pkg::*;

    // Window model and expected-item store
    class window_scoreboard;
        int unsigned cos_q[0:1024];
        int unsigned kind, len_reg, cplx;
        int unsigned idx, rem_acc, step_r;
        longint unsigned ph, step_q, csum, sqsum;
        out_item_t pending[$];
        int errors;

        function void build_cos();
            longint unsigned x, x2, t;
            longint acc, e;
            for (int k = 0; k <= 1024; k++) begin
                x = (64'd1686629713 * k + 512) / 1024;
                x2 = (x * x) >> 30;
                t = 64'd1 << 30;
                acc = t;
                for (int n = 1; n <= 9; n++) begin
                    t = ((t * x2) >> 30) / ((2 * n - 1) * (2 * n));
                    if (n % 2) acc -= t; else acc += t;
                end
                if (acc < 0) acc = 0;
                e = (acc + 16384) >>> 15;
                if (e > 32768) e = 32768;
                cos_q[k] = e;
            end
        endfunction

        function void restart();
            idx = 0; ph = 0; rem_acc = 0; step_q = 0; step_r = 0; csum = 0; sqsum = 0;
        endfunction

        function void reset_state();
            build_cos();
            kind = KIND_HANN; len_reg = 1024; cplx = 0;
            restart();
            pending.delete();
        endfunction

        function void write_reg(int unsigned addr_idx, int unsigned v);
            if (addr_idx == REG_KIND) begin
                kind = v & 3; restart();
            end else if (addr_idx == REG_LENGTH) begin
                len_reg = v & 13'h1fff; restart();
            end else if (addr_idx == REG_COMPLEX) begin
                cplx = v & 1;
            end
        endfunction

        function longint cos_at(longint unsigned p);
            longint unsigned quad, pos, i;
            p &= 16'hffff;
            quad = p >> 14;
            pos = p & 14'h3fff;
            i = (pos * 1024 + 8192) >> 14;
            if (i > 1024) i = 1024;
            case (quad)
                0: return cos_q[i];
                1: return -longint'(cos_q[1024 - i]);
                2: return -longint'(cos_q[i]);
                default: return cos_q[1024 - i];
            endcase
        endfunction

        function longint coef_at(longint unsigned p);
            longint acc;
            if (kind == KIND_RECT) return 32768;
            if (kind == KIND_HANN) acc = 64'sd16384 * 32768 - 64'sd16384 * cos_at(p);
            else if (kind == KIND_HAMMING) acc = 64'sd17695 * 32768 - 64'sd15073 * cos_at(p);
            else acc = 64'sd13763 * 32768 - 64'sd16384 * cos_at(p)
                       + 64'sd2621 * cos_at(p << 1);
            if (acc < 0) acc = 0;
            acc = (acc + 16384) >>> 15;
            if (acc > 32768) acc = 32768;
            return acc;
        endfunction

        function logic [15:0] scale(logic signed [15:0] s, longint c);
            longint p, r;
            p = longint'(s) * c + 16384;
            if (p >= 0) r = p >>> 15;
            else r = -((-p + 32767) >>> 15);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function longint unsigned enbw(longint unsigned l, longint unsigned sq,
                                       longint unsigned sm);
            longint unsigned num, den, q, r, res;
            num = l * sq; den = sm * sm;
            q = num / den; r = num % den;
            if (q >= 4) return 65535;
            res = q;
            for (int i = 0; i < 15; i++) begin
                r <<= 1; res <<= 1;
                if (r >= den) begin
                    r -= den; res |= 1;
                end
            end
            res = (res + 1) >> 1;
            return res > 65535 ? 65535 : res;
        endfunction

        // note an accepted sample and queue its expected item
        function void note_sample(in_item_t it);
            out_item_t o;
            longint unsigned len, den, cg;
            longint c;
            len = len_reg;
            if (len < 2) len = 2;
            if (len > 4096) len = 4096;
            den = len - 1;
            if (idx == 0 || idx >= len) begin
                restart();
                step_q = (65536 / den) & 16'hffff;
                step_r = 65536 % den;
            end
            c = coef_at(ph);
            o = '0;
            o.windowed_real = scale(it.sample_real, c);
            o.windowed_imag = cplx ? scale(it.sample_imag, c) : 16'd0;
            o.window_coefficient = c[15:0];
            csum += c; sqsum += c * c;
            o.last_in_window = (idx == den);
            if (o.last_in_window) begin
                if (csum == 0 || sqsum == 0) o.gain_error = 1'b1;
                else begin
                    cg = (csum + len / 2) / len;
                    o.mean_gain = (cg > 32768 ? 32768 : cg) & 16'hffff;
                    o.noise_bandwidth_bins = enbw(len, sqsum, csum);
                end
                idx = 0;
            end else begin
                ph = (ph + step_q) & 16'hffff;
                rem_acc += step_r;
                if (rem_acc >= den) begin
                    rem_acc -= den; ph = (ph + 1) & 16'hffff;
                end
                idx++;
            end
            pending.insert(pending.size(), o);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        // compare one result against the oldest expectation
        task check_item(out_item_t g);
            out_item_t e;
            if (pending.size() == 0) begin
                report("unexpected item", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (g.windowed_real !== e.windowed_real)
                report("windowed_real", g.windowed_real, e.windowed_real);
            if (g.windowed_imag !== e.windowed_imag)
                report("windowed_imag", g.windowed_imag, e.windowed_imag);
            if (g.window_coefficient !== e.window_coefficient)
                report("window_coefficient", g.window_coefficient, e.window_coefficient);
            if (g.last_in_window !== e.last_in_window)
                report("last_in_window", g.last_in_window, e.last_in_window);
            if (g.mean_gain !== e.mean_gain)
                report("mean_gain", g.mean_gain, e.mean_gain);
            if (g.noise_bandwidth_bins !== e.noise_bandwidth_bins)
                report("noise_bandwidth_bins", g.noise_bandwidth_bins,
                       e.noise_bandwidth_bins);
            if (g.gain_error !== e.gain_error)
                report("gain_error", g.gain_error, e.gain_error);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    in_item_t s_payload = '0;
    logic m_valid, m_ready = 1'b0;
    out_item_t m_payload;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    window_scoreboard frame_sb;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit hold_off = 1'b0;

    always #10 aclk = ~aclk;

    window_apply_with_gains_top uut (.*);

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) frame_sb.check_item(m_payload);
    end

    // offer one sample, hold it until accepted; valid is lowered by the
    // next call when it idles, or by drain
    task automatic send_sample(logic [15:0] re, logic [15:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= '{re, im};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_sb.note_sample('{re, im});
        @(negedge aclk);
    endtask

    task automatic apb_write(logic [1:0] r, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        frame_sb.write_reg(r, v);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // wait until every expected item is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (frame_sb.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic configure(int unsigned k, int unsigned l, int unsigned c);
        drain();
        apb_write(REG_KIND, k);
        apb_write(REG_LENGTH, l);
        apb_write(REG_COMPLEX, c);
    endtask

    task automatic random_sample();
        logic [15:0] re, im;
        case ($urandom_range(5))
            0: re = 16'h8000;
            1: re = 16'h7fff;
            default: re = 16'($urandom);
        endcase
        im = ($urandom_range(5) == 0) ? 16'h8000 : 16'($urandom);
        send_sample(re, im);
    endtask

    initial begin
        int unsigned lens[$];
        int unsigned l;
        frame_sb = new();
        frame_sb.reset_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings, then extremes of each window kind
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        configure(KIND_HANN, 2, 1);          // zero sum: gain error
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        configure(KIND_RECT, 0, 1);          // length below two acts as two
        send_sample(16'hffff, 16'h0001);
        send_sample(16'h0000, 16'hffff);
        configure(KIND_HAMMING, 3, 0);
        for (int i = 0; i < 3; i++) send_sample(16'h7fff, 16'h7fff);
        configure(KIND_BLACKMAN, 5, 1);
        for (int i = 0; i < 5; i++) send_sample(16'h8000, 16'h8000);
        configure(KIND_BLACKMAN, 3, 1);      // narrow window, wide bandwidth
        for (int i = 0; i < 3; i++) send_sample(16'h5555, 16'haaaa);
        // mid-frame restart of the frame
        send_sample(16'h1234, 16'h4321);
        drain();
        apb_write(REG_LENGTH, 4);
        for (int i = 0; i < 4; i++) send_sample(16'h7fff, 16'h8000);

        // random phases with all idling patterns
        lens = '{2, 3, 7, 16, 33, 64, 8191, 5000};
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 49 : 0;
            recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 10 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                l = ($urandom_range(9) == 0) ? lens[$urandom_range(7)]
                                             : $urandom_range(2, 40);
                configure($urandom_range(3), l, $urandom_range(1));
                for (int i = 0; i < 70; i++) random_sample();
            end
        end

        // receiver holds off while samples keep coming
        configure(KIND_HAMMING, 8, 1);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) random_sample();
        join

        drain();
        if (frame_sb.errors == 0 && frame_sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(20ns * 3000000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
